// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LAV_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("look_at_view_matrix: assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LAV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("look_at_view_matrix: assertion failed");

`endif

// ===== hdl/lav_pkg.sv =====
// Types and constants of the look-at view matrix pipeline.
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

	localparam int IN_W    = 32;
	localparam int AXIS_W  = 32;
	localparam int TRANS_W = 34;
	localparam int WIDE_W  = 64;

	typedef logic signed [IN_W-1:0]    q16_t;
	typedef logic signed [AXIS_W-1:0]  axis_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic signed [TRANS_W-1:0] trans_t;

	// unit scaling: leading-zero steps, root bits, quotient bits
	localparam int LZ_STEPS  = 6;
	localparam int ROOT_BITS = 31;
	localparam int QUO_BITS  = 31;

	// abs, lz steps, shift, square, sum, root, numerator, divide, sign
	localparam int NORM_LAT  = 1 + LZ_STEPS + 1 + 1 + 1 + ROOT_BITS + 1 + QUO_BITS + 1;
	localparam int CROSS_LAT = 2;
	localparam int DOT_LAT   = 3;
	localparam int TOTAL_LAT = 1 + 3 * NORM_LAT + 2 * CROSS_LAT + DOT_LAT;

endpackage
`default_nettype wire

// ===== hdl/lav_delay.sv =====
// Fixed-depth delay line for words that ride alongside the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module lav_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/lav_norm.sv =====
// Pipelined unit-length scaling of a three-component vector to Q2.30.
`timescale 1ns / 1ps
`default_nettype none
module lav_norm import lav_pkg::*; (
	input  logic  clk,
	input  wide_t v [3],
	output axis_t r [3]
);

	// magnitudes and signs
	logic [62:0] ab_c [3];
	logic [62:0] ab_s1 [3];
	logic [62:0] or_s1;
	logic [2:0]  neg_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ab_c[i] = v[i][WIDE_W-1] ? 63'(-v[i]) : 63'(v[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ab_s1[i]  <= ab_c[i];
			neg_s1[i] <= v[i][WIDE_W-1];
		end
		or_s1 <= ab_c[0] | ab_c[1] | ab_c[2];
	end

	// leading-zero count of the OR word, one halving step per stage
	logic [62:0] lz_word_s [0:LZ_STEPS];
	logic [5:0]  lz_cnt_s  [0:LZ_STEPS];
	logic [62:0] lz_ab_s   [0:LZ_STEPS][3];
	logic [2:0]  lz_neg_s  [0:LZ_STEPS];

	assign lz_word_s[0] = or_s1;
	assign lz_cnt_s[0]  = '0;
	assign lz_ab_s[0]   = ab_s1;
	assign lz_neg_s[0]  = neg_s1;

	for (genvar k = 0; k < LZ_STEPS; k++) begin : g_lz
		localparam int STEP = 1 << (LZ_STEPS - 1 - k);
		always_ff @(posedge clk) begin
			if (lz_word_s[k][62 -: STEP] == '0) begin
				lz_word_s[k+1] <= lz_word_s[k] << STEP;
				lz_cnt_s[k+1]  <= lz_cnt_s[k] + 6'(STEP);
			end else begin
				lz_word_s[k+1] <= lz_word_s[k];
				lz_cnt_s[k+1]  <= lz_cnt_s[k];
			end
			lz_ab_s[k+1]  <= lz_ab_s[k];
			lz_neg_s[k+1] <= lz_neg_s[k];
		end
	end

	// bring the largest magnitude to 30 bits
	logic [5:0]  lz;
	logic [29:0] sh_c [3];
	logic [29:0] sh_a_s [3];
	logic [2:0]  sh_neg_s;
	logic        sh_zero_s;

	assign lz = lz_cnt_s[LZ_STEPS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lz < 6'd33) begin
				sh_c[i] = 30'(lz_ab_s[LZ_STEPS][i] >> (6'd33 - lz));
			end else begin
				sh_c[i] = 30'(lz_ab_s[LZ_STEPS][i] << (lz - 6'd33));
			end
		end
	end

	always_ff @(posedge clk) begin
		sh_a_s    <= sh_c;
		sh_neg_s  <= lz_neg_s[LZ_STEPS];
		sh_zero_s <= ~lz_word_s[LZ_STEPS][62];
	end

	// squares, then their sum
	logic [59:0] sq_s [3];
	logic [29:0] sq_a_s [3];
	logic [2:0]  sq_neg_s;
	logic        sq_zero_s;
	logic [61:0] sum_s;
	logic [29:0] sum_a_s [3];
	logic [2:0]  sum_neg_s;
	logic        sum_zero_s;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s[i] <= 60'(sh_a_s[i]) * 60'(sh_a_s[i]);
		end
		sq_a_s     <= sh_a_s;
		sq_neg_s   <= sh_neg_s;
		sq_zero_s  <= sh_zero_s;
		sum_s      <= 62'(sq_s[0]) + 62'(sq_s[1]) + 62'(sq_s[2]);
		sum_a_s    <= sq_a_s;
		sum_neg_s  <= sq_neg_s;
		sum_zero_s <= sq_zero_s;
	end

	// floor square root, one result bit per stage
	logic [61:0] rt_rem_s  [0:ROOT_BITS];
	logic [30:0] rt_res_s  [0:ROOT_BITS];
	logic [29:0] rt_a_s    [0:ROOT_BITS][3];
	logic [2:0]  rt_neg_s  [0:ROOT_BITS];
	logic        rt_zero_s [0:ROOT_BITS];

	assign rt_rem_s[0]  = sum_s;
	assign rt_res_s[0]  = '0;
	assign rt_a_s[0]    = sum_a_s;
	assign rt_neg_s[0]  = sum_neg_s;
	assign rt_zero_s[0] = sum_zero_s;

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
		localparam int B = ROOT_BITS - 1 - j;
		logic [61:0] trial;
		assign trial = (62'(rt_res_s[j]) << (B + 1)) | (62'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (rt_rem_s[j] >= trial) begin
				rt_rem_s[j+1] <= rt_rem_s[j] - trial;
				rt_res_s[j+1] <= rt_res_s[j] | (31'(1) << B);
			end else begin
				rt_rem_s[j+1] <= rt_rem_s[j];
				rt_res_s[j+1] <= rt_res_s[j];
			end
			rt_a_s[j+1]    <= rt_a_s[j];
			rt_neg_s[j+1]  <= rt_neg_s[j];
			rt_zero_s[j+1] <= rt_zero_s[j];
		end
	end

	// rounded numerators
	logic [61:0] num_s [3];
	logic [30:0] num_mag_s;
	logic [2:0]  num_neg_s;
	logic        num_zero_s;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s[i] <= (62'(rt_a_s[ROOT_BITS][i]) << 30) + 62'(rt_res_s[ROOT_BITS] >> 1);
		end
		num_mag_s  <= rt_res_s[ROOT_BITS];
		num_neg_s  <= rt_neg_s[ROOT_BITS];
		num_zero_s <= rt_zero_s[ROOT_BITS];
	end

	// restoring division, one quotient bit per stage, three lanes
	logic [61:0] dv_rem_s  [0:QUO_BITS][3];
	logic [30:0] dv_q_s    [0:QUO_BITS][3];
	logic [30:0] dv_mag_s  [0:QUO_BITS];
	logic [2:0]  dv_neg_s  [0:QUO_BITS];
	logic        dv_zero_s [0:QUO_BITS];

	assign dv_rem_s[0]  = num_s;
	assign dv_q_s[0]    = '{default: '0};
	assign dv_mag_s[0]  = num_mag_s;
	assign dv_neg_s[0]  = num_neg_s;
	assign dv_zero_s[0] = num_zero_s;

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
		localparam int B = QUO_BITS - 1 - j;
		logic [61:0] den;
		assign den = 62'(dv_mag_s[j]) << B;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[j][i] >= den) begin
					dv_rem_s[j+1][i] <= dv_rem_s[j][i] - den;
					dv_q_s[j+1][i]   <= dv_q_s[j][i] | (31'(1) << B);
				end else begin
					dv_rem_s[j+1][i] <= dv_rem_s[j][i];
					dv_q_s[j+1][i]   <= dv_q_s[j][i];
				end
			end
			dv_mag_s[j+1]  <= dv_mag_s[j];
			dv_neg_s[j+1]  <= dv_neg_s[j];
			dv_zero_s[j+1] <= dv_zero_s[j];
		end
	end

	// apply signs; a zero vector stays zero
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[QUO_BITS]) begin
				r[i] <= '0;
			end else if (dv_neg_s[QUO_BITS][i]) begin
				r[i] <= -axis_t'({1'b0, dv_q_s[QUO_BITS][i]});
			end else begin
				r[i] <= axis_t'({1'b0, dv_q_s[QUO_BITS][i]});
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lav_cross.sv =====
// Two-stage exact cross product of two 32-bit signed vectors.
`timescale 1ns / 1ps
`default_nettype none
module lav_cross import lav_pkg::*; (
	input  logic  clk,
	input  axis_t a [3],
	input  axis_t b [3],
	output wide_t c [3]
);

	wide_t p_s1 [6];

	always_ff @(posedge clk) begin
		p_s1[0] <= a[1] * b[2];
		p_s1[1] <= a[2] * b[1];
		p_s1[2] <= a[2] * b[0];
		p_s1[3] <= a[0] * b[2];
		p_s1[4] <= a[0] * b[1];
		p_s1[5] <= a[1] * b[0];
	end

	// differences stay within 63 bits for unit-scale operands
	always_ff @(posedge clk) begin
		c[0] <= p_s1[0] - p_s1[1];
		c[1] <= p_s1[2] - p_s1[3];
		c[2] <= p_s1[4] - p_s1[5];
	end

endmodule
`default_nettype wire

// ===== hdl/lav_dot.sv =====
// Three-stage negated dot product of a unit axis and the eye, rounded to Q18.16.
`timescale 1ns / 1ps
`default_nettype none
module lav_dot import lav_pkg::*; (
	input  logic   clk,
	input  axis_t  ax  [3],
	input  q16_t   eye [3],
	output trans_t t
);

	localparam logic signed [66:0] HALF_Q30 = 67'sh2000_0000;
	localparam logic signed [36:0] T_MAX    = 37'sh1_FFFF_FFFF;
	localparam logic signed [36:0] T_MIN    = -37'sh2_0000_0000;

	wide_t              p_s1 [3];
	logic signed [65:0] sum_s2;
	logic signed [66:0] rnd_c;
	logic signed [36:0] shf_c;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= ax[i] * eye[i];
		end
		sum_s2 <= 66'(p_s1[0]) + 66'(p_s1[1]) + 66'(p_s1[2]);
	end

	// negate, round half up, floor shift by 30
	assign rnd_c = HALF_Q30 - 67'(sum_s2);
	assign shf_c = 37'(rnd_c >>> 30);

	always_ff @(posedge clk) begin
		if (shf_c > T_MAX) begin
			t <= trans_t'(T_MAX);
		end else if (shf_c < T_MIN) begin
			t <= trans_t'(T_MIN);
		end else begin
			t <= trans_t'(shf_c);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/look_at_view_matrix.sv =====
// Top level of the look-at view matrix pipeline.
//
//   channel   handshake        word
//   --------  ---------------  -------------------------------------------
//   command   start / busy     eye_*, target_*, up_* (Q16.16)
//   result    done (strobe)    side_*, upaxis_*, fwd_* (Q2.30), trans_* (Q18.16)
//
// A word is taken at every rising edge with start high and busy low; busy
// stays low, so one word enters each cycle. done marks each result word,
// in order. The path runs through three unit-scaling passes of 74 stages
// each (bitwise square root and bitwise divide), two cross products and
// the translation dot products.
// arst_n clears only the valid chain; data stages carry no reset.
// The receiver cannot stall, so nothing ever waits inside the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module look_at_view_matrix import lav_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  q16_t   eye_x,
	input  q16_t   eye_y,
	input  q16_t   eye_z,
	input  q16_t   target_x,
	input  q16_t   target_y,
	input  q16_t   target_z,
	input  q16_t   up_x,
	input  q16_t   up_y,
	input  q16_t   up_z,
	output logic   done,
	output axis_t  side_x,
	output axis_t  side_y,
	output axis_t  side_z,
	output axis_t  upaxis_x,
	output axis_t  upaxis_y,
	output axis_t  upaxis_z,
	output axis_t  fwd_x,
	output axis_t  fwd_y,
	output axis_t  fwd_z,
	output trans_t trans_x,
	output trans_t trans_y,
	output trans_t trans_z
);

	localparam int VEC_W = 3 * AXIS_W;

	// never stalls
	assign busy = 1'b0;

	// valid chain, one bit per pipeline stage
	logic [TOTAL_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[TOTAL_LAT-1];

	// input stage: register eye, up and the forward difference
	q16_t  eye_c [3];
	q16_t  tgt_c [3];
	q16_t  up_c  [3];
	q16_t  eye_s1 [3];
	axis_t up_s1  [3];
	wide_t d_s1   [3];

	assign eye_c = '{eye_x, eye_y, eye_z};
	assign tgt_c = '{target_x, target_y, target_z};
	assign up_c  = '{up_x, up_y, up_z};

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			eye_s1[i] <= eye_c[i];
			up_s1[i]  <= up_c[i];
			d_s1[i]   <= wide_t'(eye_c[i]) - wide_t'(tgt_c[i]);
		end
	end

	// forward axis
	axis_t f_n [3];

	lav_norm u_norm_f (
		.clk (clk),
		.v   (d_s1),
		.r   (f_n)
	);

	// hold up until the forward axis is out
	logic [VEC_W-1:0] up_dly;
	axis_t            up_d [3];

	lav_delay #(.WIDTH(VEC_W), .DEPTH(NORM_LAT)) u_dly_up (
		.clk (clk),
		.d   ({up_s1[2], up_s1[1], up_s1[0]}),
		.q   (up_dly)
	);

	assign up_d = '{up_dly[AXIS_W-1:0], up_dly[2*AXIS_W-1:AXIS_W], up_dly[VEC_W-1:2*AXIS_W]};

	// side axis = up x f
	wide_t c_s [3];
	axis_t s_n [3];

	lav_cross u_cross_s (
		.clk (clk),
		.a   (up_d),
		.b   (f_n),
		.c   (c_s)
	);

	lav_norm u_norm_s (
		.clk (clk),
		.v   (c_s),
		.r   (s_n)
	);

	// hold f until the side axis is out
	logic [VEC_W-1:0] f_dly1;
	axis_t            f_d1 [3];

	lav_delay #(.WIDTH(VEC_W), .DEPTH(NORM_LAT + CROSS_LAT)) u_dly_f1 (
		.clk (clk),
		.d   ({f_n[2], f_n[1], f_n[0]}),
		.q   (f_dly1)
	);

	assign f_d1 = '{f_dly1[AXIS_W-1:0], f_dly1[2*AXIS_W-1:AXIS_W], f_dly1[VEC_W-1:2*AXIS_W]};

	// up axis = f x s
	wide_t c_u [3];
	axis_t u_n [3];

	lav_cross u_cross_u (
		.clk (clk),
		.a   (f_d1),
		.b   (s_n),
		.c   (c_u)
	);

	lav_norm u_norm_u (
		.clk (clk),
		.v   (c_u),
		.r   (u_n)
	);

	// align all three axes and the eye with the up axis
	logic [VEC_W-1:0] f_dly2;
	logic [VEC_W-1:0] s_dly;
	logic [VEC_W-1:0] eye_dly;
	q16_t             eye_d [3];

	lav_delay #(.WIDTH(VEC_W), .DEPTH(NORM_LAT + CROSS_LAT + DOT_LAT)) u_dly_f2 (
		.clk (clk),
		.d   (f_dly1),
		.q   (f_dly2)
	);

	lav_delay #(.WIDTH(VEC_W), .DEPTH(NORM_LAT + CROSS_LAT + DOT_LAT)) u_dly_s (
		.clk (clk),
		.d   ({s_n[2], s_n[1], s_n[0]}),
		.q   (s_dly)
	);

	lav_delay #(.WIDTH(VEC_W), .DEPTH(3 * NORM_LAT + 2 * CROSS_LAT)) u_dly_eye (
		.clk (clk),
		.d   ({eye_s1[2], eye_s1[1], eye_s1[0]}),
		.q   (eye_dly)
	);

	assign eye_d = '{eye_dly[AXIS_W-1:0], eye_dly[2*AXIS_W-1:AXIS_W],
		eye_dly[VEC_W-1:2*AXIS_W]};

	// s and f at the up-axis point, for the translation
	axis_t s_t [3];
	axis_t f_t [3];
	logic [VEC_W-1:0] s_tdly;
	logic [VEC_W-1:0] f_tdly;
	logic [VEC_W-1:0] u_dly;

	lav_delay #(.WIDTH(VEC_W), .DEPTH(DOT_LAT)) u_dly_u (
		.clk (clk),
		.d   ({u_n[2], u_n[1], u_n[0]}),
		.q   (u_dly)
	);

	// shorter copies of the s and f lines feed the dot products
	lav_delay #(.WIDTH(VEC_W), .DEPTH(NORM_LAT + CROSS_LAT)) u_dly_st (
		.clk (clk),
		.d   ({s_n[2], s_n[1], s_n[0]}),
		.q   (s_tdly)
	);

	lav_delay #(.WIDTH(VEC_W), .DEPTH(NORM_LAT + CROSS_LAT)) u_dly_ft (
		.clk (clk),
		.d   (f_dly1),
		.q   (f_tdly)
	);

	assign s_t = '{s_tdly[AXIS_W-1:0], s_tdly[2*AXIS_W-1:AXIS_W], s_tdly[VEC_W-1:2*AXIS_W]};
	assign f_t = '{f_tdly[AXIS_W-1:0], f_tdly[2*AXIS_W-1:AXIS_W], f_tdly[VEC_W-1:2*AXIS_W]};

	lav_dot u_dot_s (
		.clk (clk),
		.ax  (s_t),
		.eye (eye_d),
		.t   (trans_x)
	);

	lav_dot u_dot_u (
		.clk (clk),
		.ax  (u_n),
		.eye (eye_d),
		.t   (trans_y)
	);

	lav_dot u_dot_f (
		.clk (clk),
		.ax  (f_t),
		.eye (eye_d),
		.t   (trans_z)
	);

	// result rows
	assign side_x   = axis_t'(s_dly[AXIS_W-1:0]);
	assign side_y   = axis_t'(s_dly[2*AXIS_W-1:AXIS_W]);
	assign side_z   = axis_t'(s_dly[VEC_W-1:2*AXIS_W]);
	assign upaxis_x = axis_t'(u_dly[AXIS_W-1:0]);
	assign upaxis_y = axis_t'(u_dly[2*AXIS_W-1:AXIS_W]);
	assign upaxis_z = axis_t'(u_dly[VEC_W-1:2*AXIS_W]);
	assign fwd_x    = axis_t'(f_dly2[AXIS_W-1:0]);
	assign fwd_y    = axis_t'(f_dly2[2*AXIS_W-1:AXIS_W]);
	assign fwd_z    = axis_t'(f_dly2[VEC_W-1:2*AXIS_W]);

	// a result only ever comes from a word taken the full latency earlier
	`LAV_ASSERT_IMPL(a_done_from_start, done, $past(start, TOTAL_LAT))
	// the x entry of the side axis never exceeds one in magnitude
	`LAV_ASSERT_IMPL(a_side_range, done,
		side_x <= 32'sh4000_0000 && side_x >= -32'sh4000_0000)
	// a zero forward axis forces a zero side axis
	`LAV_ASSERT_IMPL(a_fwd_zero, done && fwd_x == 0 && fwd_y == 0 && fwd_z == 0,
		side_x == 0 && side_y == 0 && side_z == 0)
	// a zero side axis forces a zero up axis
	`LAV_ASSERT_IMPL(a_side_zero, done && side_x == 0 && side_y == 0 && side_z == 0,
		upaxis_x == 0 && upaxis_y == 0 && upaxis_z == 0)

endmodule
`default_nettype wire
